@@ rtl/core/rfct_pkg.sv @@
// ----------------------------------------------------------------------------
// rfct_pkg
// Types and constants shared by the fan remote code tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rfct_pkg;

    localparam int unsigned FAN_COUNT = 16;

    localparam logic [5:0] PROTO_MIN      = 6'd11;
    localparam logic [5:0] PROTO_MAX      = 6'd13;
    localparam logic [6:0] CODE_BITS      = 7'd12;
    localparam logic [15:0] WINDOW_RESET  = 16'd500;

    // command word, low six bits of the code
    localparam logic [5:0] CMD_REVERSE = 6'h3b;
    localparam logic [5:0] CMD_TOP     = 6'h36;
    localparam logic [5:0] CMD_LIGHT   = 6'h3e;
    localparam logic [5:0] CMD_SPEED1  = 6'h37;
    localparam logic [5:0] CMD_SPEED2  = 6'h35;
    localparam logic [5:0] CMD_SPEED3  = 6'h2f;
    localparam logic [5:0] CMD_SPEED4  = 6'h27;
    localparam logic [5:0] CMD_SPEED5  = 6'h1d;
    localparam logic [5:0] CMD_SPEED6  = 6'h1f;
    localparam logic [5:0] CMD_OFF     = 6'h3d;

    typedef struct packed {
        logic [31:0] rf_code;
        logic [5:0]  protocol_number;
        logic [6:0]  bit_count;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [3:0] fan_index;
        logic       fade_on;
        logic       reverse_on;
        logic       light_on;
        logic       top_light_on;
        logic       motor_on;
        logic [2:0] speed_level;
    } out_t;

    typedef struct packed {
        logic [2:0] speed;
        logic       motor;
        logic       top;
        logic       light;
        logic       reverse;
        logic       fade;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EVAL   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit_prev;
        logic write_rec;
    } cmd_t;

    typedef struct packed {
        logic keep;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/rf_fan_remote_code_tracker_core.sv @@
// An item passes these steps to the output register: capture, then filter and
// repeat check, then record update. A new item is taken only once the last
// has left them. The update step waits while the output register still
// holds an item that has not been taken, and the next item can be accepted
// while a result waits. Rejected codes and dropped repeats give no result and
// go from the filter step straight back to idle. All 16 fan records clear at
// reset; the repeat window may be written whenever the block is idle.
// ----------------------------------------------------------------------------
// rf_fan_remote_code_tracker_core
// Top level: sequencer and datapath of the fan remote code tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module rf_fan_remote_code_tracker_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  rfct_pkg::in_t      s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rfct_pkg::out_t     m_data,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data
);

    rfct_pkg::cmd_t cmd;
    rfct_pkg::sts_t sts;

    rfct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rfct_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/core/rfct_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfct_ctrl
// Sequencer: capture an item, evaluate filter and repeat window, update record.
// ----------------------------------------------------------------------------
`default_nettype none

module rfct_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  rfct_pkg::sts_t     sts,
    output rfct_pkg::cmd_t     cmd
);

    rfct_pkg::state_t state_reg;
    rfct_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rfct_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        cmd.capture     = 1'b0;
        cmd.commit_prev = 1'b0;
        cmd.write_rec   = 1'b0;
        unique case (state_reg)
            rfct_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = rfct_pkg::ST_EVAL;
                end
            end
            rfct_pkg::ST_EVAL: begin
                cmd.commit_prev = sts.keep;
                state_next = sts.keep ? rfct_pkg::ST_UPDATE : rfct_pkg::ST_IDLE;
            end
            rfct_pkg::ST_UPDATE: begin
                // hold until the output register can take the item
                cmd.write_rec = sts.out_free;
                if (sts.out_free) begin
                    state_next = rfct_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rfct_pkg::ST_IDLE;
            end
        endcase
    end

    a_write_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_rec |-> sts.out_free)
        else $error("record written while output register busy");

    a_capture_to_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == rfct_pkg::ST_EVAL)
        else $error("captured item not evaluated");

    a_keep_to_update: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_prev |=> state_reg == rfct_pkg::ST_UPDATE)
        else $error("kept item did not reach update");

endmodule

`default_nettype wire

@@ rtl/core/rfct_dp.sv @@
// ----------------------------------------------------------------------------
// rfct_dp
// Datapath: input capture, repeat filter, fan record table and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfct_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  rfct_pkg::in_t      s_data,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data,
    input  rfct_pkg::cmd_t     cmd,
    output rfct_pkg::sts_t     sts,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rfct_pkg::out_t     m_data
);

    rfct_pkg::in_t  in_reg;
    rfct_pkg::out_t out_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [15:0]    window_reg;
    logic [31:0]    prev_code_reg;
    logic [31:0]    prev_time_reg;
    rfct_pkg::rec_t rec_reg [rfct_pkg::FAN_COUNT];
    rfct_pkg::rec_t rec_next;
    rfct_pkg::rec_t rec_cur;
    logic [3:0]     idx;
    logic [31:0]    elapsed;
    logic           pass;
    logic           repeat_hit;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= rfct_pkg::WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    // filter on protocol, length and bit 11, then the repeat window
    assign pass = (in_reg.protocol_number >= rfct_pkg::PROTO_MIN)
               && (in_reg.protocol_number <= rfct_pkg::PROTO_MAX)
               && (in_reg.bit_count == rfct_pkg::CODE_BITS)
               && !in_reg.rf_code[11];
    assign elapsed    = in_reg.now_ms - prev_time_reg;
    assign repeat_hit = (in_reg.rf_code == prev_code_reg) && (elapsed < {16'd0, window_reg});
    assign sts.keep   = pass && !repeat_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_code_reg <= '0;
            prev_time_reg <= '0;
        end else if (cmd.commit_prev) begin
            prev_code_reg <= in_reg.rf_code;
            prev_time_reg <= in_reg.now_ms;
        end
    end

    assign idx     = ~in_reg.rf_code[10:7];
    assign rec_cur = rec_reg[idx];

    always_comb begin
        rec_next      = rec_cur;
        rec_next.fade = !in_reg.rf_code[6];
        unique case (in_reg.rf_code[5:0])
            rfct_pkg::CMD_REVERSE: rec_next.reverse = !rec_cur.reverse;
            rfct_pkg::CMD_TOP:     rec_next.top     = !rec_cur.top;
            rfct_pkg::CMD_LIGHT:   rec_next.light   = !rec_cur.light;
            rfct_pkg::CMD_SPEED1: begin
                rec_next.speed = 3'd0;
                rec_next.motor = 1'b1;
            end
            rfct_pkg::CMD_SPEED2: begin
                rec_next.speed = 3'd1;
                rec_next.motor = 1'b1;
            end
            rfct_pkg::CMD_SPEED3: begin
                rec_next.speed = 3'd2;
                rec_next.motor = 1'b1;
            end
            rfct_pkg::CMD_SPEED4: begin
                rec_next.speed = 3'd3;
                rec_next.motor = 1'b1;
            end
            rfct_pkg::CMD_SPEED5: begin
                rec_next.speed = 3'd4;
                rec_next.motor = 1'b1;
            end
            rfct_pkg::CMD_SPEED6: begin
                rec_next.speed = 3'd5;
                rec_next.motor = 1'b1;
            end
            rfct_pkg::CMD_OFF:     rec_next.motor   = 1'b0;
            default: begin
                // unknown command, fade flag only
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rfct_pkg::FAN_COUNT; i++) begin
                rec_reg[i] <= '0;
            end
        end else if (cmd.write_rec) begin
            rec_reg[idx] <= rec_next;
        end
    end

    assign sts.out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.write_rec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_rec) begin
            out_reg.fan_index    <= idx;
            out_reg.fade_on      <= rec_next.fade;
            out_reg.reverse_on   <= rec_next.reverse;
            out_reg.light_on     <= rec_next.light;
            out_reg.top_light_on <= rec_next.top;
            out_reg.motor_on     <= rec_next.motor;
            out_reg.speed_level  <= rec_next.speed;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_write_shows_item: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_rec |=> out_valid_reg)
        else $error("written record not presented");

    a_prev_tracks_code: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_prev |=> prev_code_reg == $past(in_reg.rf_code))
        else $error("previous code not updated");

    a_keep_is_filtered: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_prev |-> !in_reg.rf_code[11] && in_reg.bit_count == rfct_pkg::CODE_BITS)
        else $error("rejected code committed");

endmodule

`default_nettype wire
